// ----- sv/pressure_sensor_compensation_core_assert.svh -----
// assertion macros used by psc_checker, the checker file of the compensation core
// no dependencies; clk and rst_n are taken from the scope of use
`ifndef PRESSURE_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent after the delay given by dly
`define PSC_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ----- sv/psc_pkg.sv -----
// shared constants and types for the pressure sensor compensation core
// no dependencies
package psc_pkg;

    localparam int RAW_W      = 24;
    localparam int COEF_W     = 16;
    localparam int TEMP_W     = 15;
    localparam int PRES_W     = 18;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int PIPE_DEPTH = 11;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_SENS        = 3'd0;
    localparam reg_idx_t REG_OFFSET      = 3'd1;
    localparam reg_idx_t REG_SENS_TEMP   = 3'd2;
    localparam reg_idx_t REG_OFFSET_TEMP = 3'd3;
    localparam reg_idx_t REG_REF_TEMP    = 3'd4;
    localparam reg_idx_t REG_TEMP_SLOPE  = 3'd5;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN_CENTI = -15'sd4000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_CENTI = 15'sd8500;
    localparam logic [PRES_W-1:0]        PRES_MAX_DECI  = 18'd140000;

endpackage

// ----- sv/pressure_sensor_compensation_core.sv -----
// pressure sensor compensation core: first and second order correction, six calibration words
// depends on psc_pkg; checker attached by bind from psc_checker
// a word taken at one edge shows on the result ports after the 11-stage datapath pipeline, done high
// for one cycle; throughput one word per cycle, set by the datapath pipeline
// busy never rises; async active-low reset clears calibration words and stage valids
module pressure_sensor_compensation_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [psc_pkg::APB_AW-1:0]           paddr,
    input  logic [psc_pkg::APB_DW-1:0]           pwdata,
    output logic [psc_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready,
    // command side
    input  logic                                 start,
    output logic                                 busy,
    input  logic [psc_pkg::RAW_W-1:0]            raw_pressure,
    input  logic [psc_pkg::RAW_W-1:0]            raw_temperature,
    // result side
    output logic                                 done,
    output logic signed [psc_pkg::TEMP_W-1:0]    temperature_centi,
    output logic [psc_pkg::PRES_W-1:0]           pressure_deci_mbar,
    output logic                                 clamped
);
    import psc_pkg::*;

    // ------------------------------------------------------------------
    // calibration words
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] sens_coeff_reg;
    logic [COEF_W-1:0] offset_coeff_reg;
    logic [COEF_W-1:0] sens_temp_coeff_reg;
    logic [COEF_W-1:0] offset_temp_coeff_reg;
    logic [COEF_W-1:0] ref_temp_coeff_reg;
    logic [COEF_W-1:0] temp_slope_coeff_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    // word index from the byte address, low two bits ignored
    assign cfg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_coeff_reg        <= '0;
            offset_coeff_reg      <= '0;
            sens_temp_coeff_reg   <= '0;
            offset_temp_coeff_reg <= '0;
            ref_temp_coeff_reg    <= '0;
            temp_slope_coeff_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            // writes past the last register fall into the default arm and are dropped
            unique case (cfg_idx)
                REG_SENS:        sens_coeff_reg        <= pwdata[COEF_W-1:0];
                REG_OFFSET:      offset_coeff_reg      <= pwdata[COEF_W-1:0];
                REG_SENS_TEMP:   sens_temp_coeff_reg   <= pwdata[COEF_W-1:0];
                REG_OFFSET_TEMP: offset_temp_coeff_reg <= pwdata[COEF_W-1:0];
                REG_REF_TEMP:    ref_temp_coeff_reg    <= pwdata[COEF_W-1:0];
                REG_TEMP_SLOPE:  temp_slope_coeff_reg  <= pwdata[COEF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // read-back, zero extended
    always_comb
    begin
        unique case (cfg_idx)
            REG_SENS:        prdata = {16'h0000, sens_coeff_reg};
            REG_OFFSET:      prdata = {16'h0000, offset_coeff_reg};
            REG_SENS_TEMP:   prdata = {16'h0000, sens_temp_coeff_reg};
            REG_OFFSET_TEMP: prdata = {16'h0000, offset_temp_coeff_reg};
            REG_REF_TEMP:    prdata = {16'h0000, ref_temp_coeff_reg};
            REG_TEMP_SLOPE:  prdata = {16'h0000, temp_slope_coeff_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake and stage valids
    // ------------------------------------------------------------------
    logic                  accept;
    logic [PIPE_DEPTH-1:0] vld_reg;

    // the pipeline never stalls, so a word is taken in every cycle start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign done   = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: temperature difference dT against the reference word
    // ------------------------------------------------------------------
    logic signed [24:0] s1_dt_next;
    logic signed [24:0] s1_dt_reg;
    logic [RAW_W-1:0]   s1_d1_reg;

    assign s1_dt_next = $signed({1'b0, raw_temperature})
                      - $signed({1'b0, ref_temp_coeff_reg, 8'h00});

    always_ff @(posedge clk)
    begin
        s1_dt_reg <= s1_dt_next;
        s1_d1_reg <= raw_pressure;
    end

    // ------------------------------------------------------------------
    // stage 2: the four products of dT
    // ------------------------------------------------------------------
    logic signed [41:0] s2_ts_next;
    logic signed [41:0] s2_offt_next;
    logic signed [41:0] s2_senst_next;
    logic signed [49:0] s2_dd_full;
    logic signed [41:0] s2_ts_reg;
    logic signed [41:0] s2_offt_reg;
    logic signed [41:0] s2_senst_reg;
    logic [47:0]        s2_dd_reg;
    logic [RAW_W-1:0]   s2_d1_reg;

    assign s2_ts_next    = s1_dt_reg * $signed({1'b0, temp_slope_coeff_reg});
    assign s2_offt_next  = s1_dt_reg * $signed({1'b0, offset_temp_coeff_reg});
    assign s2_senst_next = s1_dt_reg * $signed({1'b0, sens_temp_coeff_reg});
    // dT squared stays below 2^48
    assign s2_dd_full    = s1_dt_reg * s1_dt_reg;

    always_ff @(posedge clk)
    begin
        s2_ts_reg    <= s2_ts_next;
        s2_offt_reg  <= s2_offt_next;
        s2_senst_reg <= s2_senst_next;
        s2_dd_reg    <= s2_dd_full[47:0];
        s2_d1_reg    <= s1_d1_reg;
    end

    // ------------------------------------------------------------------
    // stage 3: truncating shifts, first-order OFF and SENS, both T2 candidates
    // ------------------------------------------------------------------
    logic signed [41:0] s3_ts_adj;
    logic signed [41:0] s3_offt_adj;
    logic signed [41:0] s3_senst_adj;
    logic signed [17:0] s3_dev_next;
    logic signed [34:0] s3_off_term;
    logic signed [33:0] s3_sens_term;
    logic signed [34:0] s3_off1_next;
    logic signed [34:0] s3_sens1_next;
    logic [49:0]        s3_dd3;
    logic [50:0]        s3_dd7;
    logic signed [17:0] s3_dev_reg;
    logic signed [34:0] s3_off1_reg;
    logic signed [34:0] s3_sens1_reg;
    logic [16:0]        s3_t2lo_reg;
    logic [13:0]        s3_t2hi_reg;
    logic [RAW_W-1:0]   s3_d1_reg;

    // bias negative values so the arithmetic shift rounds toward zero
    assign s3_ts_adj    = s2_ts_reg + (s2_ts_reg[41] ? 42'sd8388607 : 42'sd0);
    assign s3_offt_adj  = s2_offt_reg + (s2_offt_reg[41] ? 42'sd127 : 42'sd0);
    assign s3_senst_adj = s2_senst_reg + (s2_senst_reg[41] ? 42'sd255 : 42'sd0);

    // dev is TEMP - 2000 of the first-order temperature
    assign s3_dev_next  = s3_ts_adj[40:23];
    assign s3_off_term  = s3_offt_adj[41:7];
    assign s3_sens_term = s3_senst_adj[41:8];

    assign s3_off1_next  = $signed({3'b000, offset_coeff_reg, 16'h0000}) + s3_off_term;
    assign s3_sens1_next = $signed({4'b0000, sens_coeff_reg, 15'h0000}) + s3_sens_term;

    // 3*dT^2 and 7*dT^2, both non-negative
    assign s3_dd3 = {2'b00, s2_dd_reg} + {1'b0, s2_dd_reg, 1'b0};
    assign s3_dd7 = {s2_dd_reg, 3'b000} - {3'b000, s2_dd_reg};

    always_ff @(posedge clk)
    begin
        s3_dev_reg   <= s3_dev_next;
        s3_off1_reg  <= s3_off1_next;
        s3_sens1_reg <= s3_sens1_next;
        s3_t2lo_reg  <= s3_dd3[49:33];
        s3_t2hi_reg  <= s3_dd7[50:37];
        s3_d1_reg    <= s2_d1_reg;
    end

    // ------------------------------------------------------------------
    // stage 4: regime flags, squares, second-order temperature
    // ------------------------------------------------------------------
    logic               s4_lo_next;
    logic               s4_vlo_next;
    logic [16:0]        s4_t2;
    logic signed [19:0] s4_temp_next;
    logic signed [35:0] s4_sq_full;
    logic signed [18:0] s4_d15;
    logic signed [37:0] s4_s15_full;
    logic               s4_lo_reg;
    logic               s4_vlo_reg;
    logic signed [19:0] s4_temp_reg;
    logic [33:0]        s4_sq_reg;
    logic [34:0]        s4_s15_reg;
    logic signed [34:0] s4_off1_reg;
    logic signed [34:0] s4_sens1_reg;
    logic [RAW_W-1:0]   s4_d1_reg;

    // below 20 C when dev < 0, below -15 C when dev < -3500
    assign s4_lo_next   = s3_dev_reg[17];
    assign s4_vlo_next  = s3_dev_reg < -18'sd3500;
    assign s4_t2        = s4_lo_next ? s3_t2lo_reg : {3'b000, s3_t2hi_reg};
    assign s4_temp_next = {{2{s3_dev_reg[17]}}, s3_dev_reg} + 20'sd2000 - {3'b000, s4_t2};

    assign s4_sq_full  = s3_dev_reg * s3_dev_reg;
    assign s4_d15      = {s3_dev_reg[17], s3_dev_reg} + 19'sd3500;
    assign s4_s15_full = s4_d15 * s4_d15;

    always_ff @(posedge clk)
    begin
        s4_lo_reg    <= s4_lo_next;
        s4_vlo_reg   <= s4_vlo_next;
        s4_temp_reg  <= s4_temp_next;
        s4_sq_reg    <= s4_sq_full[33:0];
        s4_s15_reg   <= s4_s15_full[34:0];
        s4_off1_reg  <= s3_off1_reg;
        s4_sens1_reg <= s3_sens1_reg;
        s4_d1_reg    <= s3_d1_reg;
    end

    // ------------------------------------------------------------------
    // stage 5: OFF2 and SENS2, temperature clamp
    // ------------------------------------------------------------------
    logic [35:0]               s5_sq3;
    logic [36:0]               s5_sq5;
    logic [37:0]               s5_s15x7;
    logic [36:0]               s5_s15x4;
    logic [38:0]               s5_off2_next;
    logic [37:0]               s5_sens2_next;
    logic signed [TEMP_W-1:0]  s5_temp_next;
    logic                      s5_tclip_next;
    logic [38:0]               s5_off2_reg;
    logic [37:0]               s5_sens2_reg;
    logic signed [34:0]        s5_off1_reg;
    logic signed [34:0]        s5_sens1_reg;
    logic signed [TEMP_W-1:0]  s5_temp_reg;
    logic                      s5_tclip_reg;
    logic [RAW_W-1:0]          s5_d1_reg;

    assign s5_sq3   = {2'b00, s4_sq_reg} + {1'b0, s4_sq_reg, 1'b0};
    assign s5_sq5   = {3'b000, s4_sq_reg} + {1'b0, s4_sq_reg, 2'b00};
    assign s5_s15x7 = {s4_s15_reg, 3'b000} - {3'b000, s4_s15_reg};
    assign s5_s15x4 = {s4_s15_reg, 2'b00};

    always_comb
    begin
        priority if (!s4_lo_reg)
        begin
            s5_off2_next  = {9'h000, s4_sq_reg[33:4]};
            s5_sens2_next = '0;
        end
        else if (s4_vlo_reg)
        begin
            s5_off2_next  = {4'h0, s5_sq3[35:1]} + {1'b0, s5_s15x7};
            s5_sens2_next = {4'h0, s5_sq5[36:3]} + {1'b0, s5_s15x4};
        end
        else
        begin
            s5_off2_next  = {4'h0, s5_sq3[35:1]};
            s5_sens2_next = {4'h0, s5_sq5[36:3]};
        end
    end

    always_comb
    begin
        priority if (s4_temp_reg < TEMP_MIN_CENTI)
        begin
            s5_temp_next  = TEMP_MIN_CENTI;
            s5_tclip_next = 1'b1;
        end
        else if (s4_temp_reg > TEMP_MAX_CENTI)
        begin
            s5_temp_next  = TEMP_MAX_CENTI;
            s5_tclip_next = 1'b1;
        end
        else
        begin
            s5_temp_next  = s4_temp_reg[TEMP_W-1:0];
            s5_tclip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_off2_reg  <= s5_off2_next;
        s5_sens2_reg <= s5_sens2_next;
        s5_off1_reg  <= s4_off1_reg;
        s5_sens1_reg <= s4_sens1_reg;
        s5_temp_reg  <= s5_temp_next;
        s5_tclip_reg <= s5_tclip_next;
        s5_d1_reg    <= s4_d1_reg;
    end

    // ------------------------------------------------------------------
    // stage 6: final OFF and SENS
    // ------------------------------------------------------------------
    logic signed [39:0]        s6_off1_x;
    logic signed [39:0]        s6_off2_x;
    logic signed [39:0]        s6_sens1_x;
    logic signed [39:0]        s6_sens2_x;
    logic signed [39:0]        s6_off_reg;
    logic signed [39:0]        s6_sens_reg;
    logic signed [TEMP_W-1:0]  s6_temp_reg;
    logic                      s6_tclip_reg;
    logic [RAW_W-1:0]          s6_d1_reg;

    assign s6_off1_x  = {{5{s5_off1_reg[34]}}, s5_off1_reg};
    assign s6_off2_x  = {1'b0, s5_off2_reg};
    assign s6_sens1_x = {{5{s5_sens1_reg[34]}}, s5_sens1_reg};
    assign s6_sens2_x = {2'b00, s5_sens2_reg};

    always_ff @(posedge clk)
    begin
        s6_off_reg   <= s6_off1_x - s6_off2_x;
        s6_sens_reg  <= s6_sens1_x - s6_sens2_x;
        s6_temp_reg  <= s5_temp_reg;
        s6_tclip_reg <= s5_tclip_reg;
        s6_d1_reg    <= s5_d1_reg;
    end

    // ------------------------------------------------------------------
    // stage 7: raw pressure times SENS as two partial products
    // ------------------------------------------------------------------
    logic [43:0]               s7_pplo_next;
    logic signed [44:0]        s7_pphi_next;
    logic [43:0]               s7_pplo_reg;
    logic signed [44:0]        s7_pphi_reg;
    logic signed [39:0]        s7_off_reg;
    logic signed [TEMP_W-1:0]  s7_temp_reg;
    logic                      s7_tclip_reg;

    // low half unsigned, high half carries the sign
    assign s7_pplo_next = s6_d1_reg * s6_sens_reg[19:0];
    assign s7_pphi_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[39:20]);

    always_ff @(posedge clk)
    begin
        s7_pplo_reg  <= s7_pplo_next;
        s7_pphi_reg  <= s7_pphi_next;
        s7_off_reg   <= s6_off_reg;
        s7_temp_reg  <= s6_temp_reg;
        s7_tclip_reg <= s6_tclip_reg;
    end

    // ------------------------------------------------------------------
    // stage 8: partial product sum
    // ------------------------------------------------------------------
    logic signed [64:0]        s8_prod_full;
    logic signed [63:0]        s8_prod_reg;
    logic signed [39:0]        s8_off_reg;
    logic signed [TEMP_W-1:0]  s8_temp_reg;
    logic                      s8_tclip_reg;

    assign s8_prod_full = $signed({s7_pphi_reg, 20'h00000})
                        + $signed({21'h000000, s7_pplo_reg});

    always_ff @(posedge clk)
    begin
        s8_prod_reg  <= s8_prod_full[63:0];
        s8_off_reg   <= s7_off_reg;
        s8_temp_reg  <= s7_temp_reg;
        s8_tclip_reg <= s7_tclip_reg;
    end

    // ------------------------------------------------------------------
    // stage 9: product over 2^21, toward zero
    // ------------------------------------------------------------------
    logic signed [63:0]        s9_prod_adj;
    logic signed [42:0]        s9_q_next;
    logic signed [42:0]        s9_q_reg;
    logic signed [39:0]        s9_off_reg;
    logic signed [TEMP_W-1:0]  s9_temp_reg;
    logic                      s9_tclip_reg;

    assign s9_prod_adj = s8_prod_reg + (s8_prod_reg[63] ? 64'sd2097151 : 64'sd0);
    assign s9_q_next   = s9_prod_adj[63:21];

    always_ff @(posedge clk)
    begin
        s9_q_reg     <= s9_q_next;
        s9_off_reg   <= s8_off_reg;
        s9_temp_reg  <= s8_temp_reg;
        s9_tclip_reg <= s8_tclip_reg;
    end

    // ------------------------------------------------------------------
    // stage 10: subtract OFF
    // ------------------------------------------------------------------
    logic signed [43:0]        s10_q_x;
    logic signed [43:0]        s10_off_x;
    logic signed [43:0]        s10_r_reg;
    logic signed [TEMP_W-1:0]  s10_temp_reg;
    logic                      s10_tclip_reg;

    assign s10_q_x   = {s9_q_reg[42], s9_q_reg};
    assign s10_off_x = {{4{s9_off_reg[39]}}, s9_off_reg};

    always_ff @(posedge clk)
    begin
        s10_r_reg     <= s10_q_x - s10_off_x;
        s10_temp_reg  <= s9_temp_reg;
        s10_tclip_reg <= s9_tclip_reg;
    end

    // ------------------------------------------------------------------
    // stage 11: over 2^15 toward zero, pressure clamp, result register
    // ------------------------------------------------------------------
    logic signed [43:0]        s11_r_adj;
    logic signed [28:0]        s11_p;
    logic signed [28:0]        s11_pmax;
    logic [PRES_W-1:0]         s11_pres_next;
    logic                      s11_pclip_next;
    logic signed [TEMP_W-1:0]  temp_out_reg;
    logic [PRES_W-1:0]         pres_out_reg;
    logic                      clamped_reg;

    assign s11_r_adj = s10_r_reg + (s10_r_reg[43] ? 44'sd32767 : 44'sd0);
    assign s11_p     = s11_r_adj[43:15];
    assign s11_pmax  = {11'h000, PRES_MAX_DECI};

    always_comb
    begin
        priority if (s11_p[28])
        begin
            s11_pres_next  = '0;
            s11_pclip_next = 1'b1;
        end
        else if (s11_p > s11_pmax)
        begin
            s11_pres_next  = PRES_MAX_DECI;
            s11_pclip_next = 1'b1;
        end
        else
        begin
            s11_pres_next  = s11_p[PRES_W-1:0];
            s11_pclip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_out_reg <= s10_temp_reg;
        pres_out_reg <= s11_pres_next;
        clamped_reg  <= s10_tclip_reg | s11_pclip_next;
    end

    assign temperature_centi  = temp_out_reg;
    assign pressure_deci_mbar = pres_out_reg;
    assign clamped            = clamped_reg;

endmodule

// ----- sv/psc_checker.sv -----
// port-level checks for the compensation core, attached by bind
// depends on psc_pkg and pressure_sensor_compensation_core_assert.svh
`include "pressure_sensor_compensation_core_assert.svh"

module psc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              done,
    input  logic signed [psc_pkg::TEMP_W-1:0] temperature_centi,
    input  logic [psc_pkg::PRES_W-1:0]        pressure_deci_mbar,
    input  logic                              clamped
);
    import psc_pkg::*;

    // every word taken comes out after the full pipe
    `PSC_ASSERT_DELAY(a_word_latency, start && !busy, PIPE_DEPTH, done, "word lost in pipeline")

    // no result without a word taken the pipe length before
    `PSC_ASSERT_IMPL(a_no_stray_done, done, $past(start && !busy, PIPE_DEPTH), "stray result")

    `PSC_ASSERT_IMPL(a_temp_range, done, temperature_centi >= TEMP_MIN_CENTI && temperature_centi <= TEMP_MAX_CENTI, "temperature out of range")

    `PSC_ASSERT_IMPL(a_pres_range, done, pressure_deci_mbar <= PRES_MAX_DECI || clamped, "pressure out of range")

endmodule

bind pressure_sensor_compensation_core psc_checker u_psc_checker (.*);

// ----- tb/sv/tb_psc_result_checker.sv -----
// result checker for the pressure sensor compensation core
// depends on psc_pkg; follows calibration writes, predicts every reading and compares
// each result word against the oldest prediction still waiting
module tb_psc_result_checker
    import psc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    input  logic                      start,
    input  logic                      busy,
    input  logic [RAW_W-1:0]          raw_pressure,
    input  logic [RAW_W-1:0]          raw_temperature,
    input  logic                      done,
    input  logic signed [TEMP_W-1:0]  temperature_centi,
    input  logic [PRES_W-1:0]         pressure_deci_mbar,
    input  logic                      clamped,
    output int                        mismatches,
    output int                        words_in_flight
);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        pres;
        logic                     clip;
    } reading_t;

    logic [COEF_W-1:0] cal [0:7];
    reading_t          awaited_readings [$];
    reading_t          want;
    int                errors = 0;

    assign mismatches = errors;

    // first and second order compensation, all in signed 64-bit
    function automatic reading_t compensate_reading(input logic [RAW_W-1:0] p_raw,
                                                    input logic [RAW_W-1:0] t_raw);
        longint   d1, dt, temp, off, sens, t2, off2, sens2, dev, sq, pres, d15, s15;
        reading_t r;
        d1   = longint'(p_raw);
        dt   = longint'(t_raw) - longint'(cal[REG_REF_TEMP]) * 256;
        temp = 2000 + (dt * longint'(cal[REG_TEMP_SLOPE])) / 8388608;
        off  = longint'(cal[REG_OFFSET]) * 65536 + (longint'(cal[REG_OFFSET_TEMP]) * dt) / 128;
        sens = longint'(cal[REG_SENS]) * 32768 + (longint'(cal[REG_SENS_TEMP]) * dt) / 256;
        dev  = temp - 2000;
        sq   = dev * dev;
        if (temp < 2000)
        begin
            t2    = (3 * dt * dt) / 64'sd8589934592;
            off2  = (3 * sq) / 2;
            sens2 = (5 * sq) / 8;
            if (temp < -1500)
            begin
                d15   = temp + 1500;
                s15   = d15 * d15;
                off2  = off2 + 7 * s15;
                sens2 = sens2 + 4 * s15;
            end
        end
        else
        begin
            t2    = (7 * dt * dt) / 64'sd137438953472;
            off2  = sq / 16;
            sens2 = 0;
        end
        temp   = temp - t2;
        off    = off - off2;
        sens   = sens - sens2;
        pres   = ((d1 * sens) / 2097152 - off) / 32768;
        r.clip = 1'b0;
        if (temp < longint'(TEMP_MIN_CENTI))
        begin
            temp   = longint'(TEMP_MIN_CENTI);
            r.clip = 1'b1;
        end
        if (temp > longint'(TEMP_MAX_CENTI))
        begin
            temp   = longint'(TEMP_MAX_CENTI);
            r.clip = 1'b1;
        end
        if (pres < 0)
        begin
            pres   = 0;
            r.clip = 1'b1;
        end
        if (pres > longint'(PRES_MAX_DECI))
        begin
            pres   = longint'(PRES_MAX_DECI);
            r.clip = 1'b1;
        end
        r.temp = temp[TEMP_W-1:0];
        r.pres = pres[PRES_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                cal[i] = '0;
            awaited_readings.delete();
            words_in_flight <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_AW-1:2])
                    REG_SENS, REG_OFFSET, REG_SENS_TEMP,
                    REG_OFFSET_TEMP, REG_REF_TEMP, REG_TEMP_SLOPE:
                        cal[paddr[APB_AW-1:2]] = pwdata[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (awaited_readings.size() == 0)
                begin
                    $error("result word with no reading outstanding");
                    errors++;
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    if (temperature_centi !== want.temp)
                    begin
                        $error("temperature_centi: expected %0d, got %0d",
                               want.temp, temperature_centi);
                        errors++;
                    end
                    if (pressure_deci_mbar !== want.pres)
                    begin
                        $error("pressure_deci_mbar: expected %0d, got %0d",
                               want.pres, pressure_deci_mbar);
                        errors++;
                    end
                    if (clamped !== want.clip)
                    begin
                        $error("clamped: expected %0d, got %0d", want.clip, clamped);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                awaited_readings.push_back(compensate_reading(raw_pressure, raw_temperature));
            words_in_flight <= awaited_readings.size();
        end
    end

endmodule

// ----- tb/sv/tb_pressure_sensor_compensation_core.sv -----
// testbench top for the pressure sensor compensation core
// depends on psc_pkg, pressure_sensor_compensation_core and tb_psc_result_checker
// drives calibration sets and raw readings, then reports the verdict
module tb_pressure_sensor_compensation_core;
    import psc_pkg::*;

    // run bounds: slowest legal run is roughly 1500 words with random gaps
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 180;

    // addresses past the last calibration word, writes there must be dropped
    localparam reg_idx_t REG_SPARE_LO = 3'd6;
    localparam reg_idx_t REG_SPARE_HI = 3'd7;

    // a typical factory calibration, used as the centre of most settings
    localparam logic [COEF_W-1:0] TYP_SENS        = 16'd46372;
    localparam logic [COEF_W-1:0] TYP_OFFSET      = 16'd43981;
    localparam logic [COEF_W-1:0] TYP_SENS_TEMP   = 16'd29059;
    localparam logic [COEF_W-1:0] TYP_OFFSET_TEMP = 16'd27842;
    localparam logic [COEF_W-1:0] TYP_REF_TEMP    = 16'd31553;
    localparam logic [COEF_W-1:0] TYP_TEMP_SLOPE  = 16'd28165;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;
    logic                      start;
    logic                      busy;
    logic [RAW_W-1:0]          raw_pressure;
    logic [RAW_W-1:0]          raw_temperature;
    logic                      done;
    logic signed [TEMP_W-1:0]  temperature_centi;
    logic [PRES_W-1:0]         pressure_deci_mbar;
    logic                      clamped;

    int fail_count;
    int words_pending;
    int cycle_count = 0;

    // calibration words as last written, used to aim readings near the reference
    logic [COEF_W-1:0] cal_now [0:7];
    // when set the sender offers words back to back
    bit steady;

    pressure_sensor_compensation_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .raw_pressure       (raw_pressure),
        .raw_temperature    (raw_temperature),
        .done               (done),
        .temperature_centi  (temperature_centi),
        .pressure_deci_mbar (pressure_deci_mbar),
        .clamped            (clamped)
    );

    tb_psc_result_checker result_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .start              (start),
        .busy               (busy),
        .raw_pressure       (raw_pressure),
        .raw_temperature    (raw_temperature),
        .done               (done),
        .temperature_centi  (temperature_centi),
        .pressure_deci_mbar (pressure_deci_mbar),
        .clamped            (clamped),
        .mismatches         (fail_count),
        .words_in_flight    (words_pending)
    );

    // free-running clock, period 10
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog against a hung handshake or a lost result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one register write: setup cycle, then access cycle until pready
    task automatic write_cal(input reg_idx_t idx, input logic [COEF_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // upper data bits carry noise, only the low 16 bits matter
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_TEMP_SLOPE)
            cal_now[idx] = value;
    endtask

    task automatic load_cal_set(input logic [COEF_W-1:0] sens, input logic [COEF_W-1:0] off,
                                input logic [COEF_W-1:0] sens_t, input logic [COEF_W-1:0] off_t,
                                input logic [COEF_W-1:0] ref_t, input logic [COEF_W-1:0] slope);
        write_cal(REG_SENS, sens);
        write_cal(REG_OFFSET, off);
        write_cal(REG_SENS_TEMP, sens_t);
        write_cal(REG_OFFSET_TEMP, off_t);
        write_cal(REG_REF_TEMP, ref_t);
        write_cal(REG_TEMP_SLOPE, slope);
    endtask

    // a calibration word scattered around its typical value
    function automatic logic [COEF_W-1:0] jitter(input logic [COEF_W-1:0] centre);
        return centre + 16'($urandom_range(0, 16383)) - 16'd8192;
    endfunction

    function automatic logic [COEF_W-1:0] rail();
        return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    endfunction

    // offer one reading; start is left high so the next word can follow without a gap
    task automatic send_word(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        raw_pressure    <= p;
        raw_temperature <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    // mostly readings around the reference temperature so all three regimes are hit,
    // the rest anywhere in the 24-bit range
    task automatic send_random_word();
        int               t_val;
        int               spread;
        logic [RAW_W-1:0] p;
        logic [RAW_W-1:0] t;
        if ($urandom_range(0, 3) == 0)
        begin
            p = RAW_W'($urandom_range(0, 24'hFFFFFF));
            t = RAW_W'($urandom_range(0, 24'hFFFFFF));
        end
        else
        begin
            spread = $urandom_range(0, 4194304);
            t_val  = int'(cal_now[REG_REF_TEMP]) * 256 + spread - 2097152;
            if (t_val < 0)
                t_val = 0;
            if (t_val > 24'hFFFFFF)
                t_val = 24'hFFFFFF;
            t = RAW_W'(t_val);
            p = RAW_W'($urandom_range(1000000, 12000000));
        end
        send_word(p, t);
    endtask

    // drop start in the step of the last acceptance
    task automatic stop_words();
        start <= 1'b0;
    endtask

    // one edge first so the count includes the word taken at this edge
    task automatic wait_drained();
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        // every input known from time zero
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        start           = 1'b0;
        raw_pressure    = '0;
        raw_temperature = '0;
        steady          = 1'b0;
        for (int i = 0; i < 8; i++)
            cal_now[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // a few readings on the all-zero calibration left by reset
        send_word(24'd0, 24'd0);
        send_word(24'hFFFFFF, 24'hFFFFFF);
        send_word(24'd4311550, 24'd8387300);
        stop_words();
        wait_drained();

        // typical calibration, then writes past the register map that must not land
        load_cal_set(TYP_SENS, TYP_OFFSET, TYP_SENS_TEMP, TYP_OFFSET_TEMP,
                     TYP_REF_TEMP, TYP_TEMP_SLOPE);
        write_cal(REG_SPARE_LO, 16'hFFFF);
        write_cal(REG_SPARE_HI, 16'h5A5A);

        // directed readings, reference temperature word sits at 8077568
        send_word(24'd4311550, 24'd8387300);   // nominal reading
        send_word(24'd4311550, 24'd8077568);   // exactly at reference, 20 degrees
        send_word(24'd4311550, 24'd8077567);   // tiny negative offset truncates back to 20
        send_word(24'd4311550, 24'd8077270);   // first step into the low regime
        send_word(24'd5000000, 24'd7500000);   // low regime
        send_word(24'd5000000, 24'd7040000);   // near the very low threshold
        send_word(24'd5000000, 24'd6900000);   // very low regime
        send_word(24'd5000000, 24'd6300000);   // very low, past the cold clamp
        send_word(24'd3000000, 24'd9000000);   // warm, normal regime
        send_word(24'd0, 24'd8387300);         // pressure below range
        send_word(24'hFFFFFF, 24'd8387300);    // pressure above range
        send_word(24'd0, 24'd0);               // cold clamp
        send_word(24'hFFFFFF, 24'hFFFFFF);     // hot clamp
        send_word(24'hFFFFFF, 24'd0);
        send_word(24'd0, 24'hFFFFFF);
        send_word(24'd1, 24'd1);
        send_word(24'h800000, 24'h7FFFFF);
        send_word(24'h7FFFFF, 24'h800000);
        send_word(24'hAAAAAA, 24'h555555);
        send_word(24'h555555, 24'hAAAAAA);

        // random phases, each on its own calibration set, loaded while idle
        for (int phase = 0; phase < PHASES; phase++)
        begin
            stop_words();
            wait_drained();
            case (phase)
                0: load_cal_set(TYP_SENS, TYP_OFFSET, TYP_SENS_TEMP, TYP_OFFSET_TEMP,
                                TYP_REF_TEMP, TYP_TEMP_SLOPE);
                1: load_cal_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: load_cal_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                3: load_cal_set(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom));
                4: load_cal_set(rail(), rail(), rail(), rail(), rail(), rail());
                default: load_cal_set(jitter(TYP_SENS), jitter(TYP_OFFSET),
                                      jitter(TYP_SENS_TEMP), jitter(TYP_OFFSET_TEMP),
                                      jitter(TYP_REF_TEMP), jitter(TYP_TEMP_SLOPE));
            endcase
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                // runs of twenty words, about a quarter of them back to back
                if (k % 20 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                // once in the run the sender holds off until the pipeline is empty
                if (phase == 5 && k == 90)
                begin
                    stop_words();
                    wait_drained();
                end
                send_random_word();
            end
        end

        stop_words();
        wait_drained();
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        if (fail_count == 0 && words_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
